@@ rtl/zosf_pkg.sv @@
// Shared types, constants and helpers of the zero-operand stack and flag unit.
`timescale 1ns / 1ps
`default_nettype none
package zosf_pkg;

  // Data path widths
  localparam int unsigned XLEN      = 64;
  localparam int unsigned OPCODE_W  = 4;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 264;

  // Default stack depth in 64-bit words
  localparam int unsigned STACK_WORDS_DEF = 256;

  // Flag word layout
  localparam int unsigned CARRY_BIT = 0;

  // Stack pointer steps in bytes
  localparam logic [XLEN-1:0] WORD_STEP  = 64'd8;
  localparam logic [XLEN-1:0] FRAME_STEP = 64'd64;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_BOTTOM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_TOP    = 1'b1;
  localparam logic [XLEN-1:0] STACK_BOTTOM_RST = 64'd0;
  localparam logic [XLEN-1:0] STACK_TOP_RST    = 64'd2048;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_NOP   = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_RET   = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_STC   = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_CLC   = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_CMC   = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_PUSHF = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_POPF  = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_PUSHA = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_POPA  = 4'd8;
  localparam logic [OPCODE_W-1:0] OP_LAF   = 4'd9;
  localparam logic [OPCODE_W-1:0] OP_SAF   = 4'd10;
  localparam logic [OPCODE_W-1:0] OP_LAIP  = 4'd11;
  localparam logic [OPCODE_W-1:0] OP_SAIP  = 4'd12;
  localparam logic [OPCODE_W-1:0] OP_WREG  = 4'd13;

  // General register indexes
  localparam logic [SEL_W-1:0] REG_AX = 3'd0;
  localparam logic [SEL_W-1:0] REG_BX = 3'd1;
  localparam logic [SEL_W-1:0] REG_CX = 3'd2;
  localparam logic [SEL_W-1:0] REG_DX = 3'd3;
  localparam logic [SEL_W-1:0] REG_SP = 3'd4;
  localparam logic [SEL_W-1:0] REG_BP = 3'd5;
  localparam logic [SEL_W-1:0] REG_SI = 3'd6;
  localparam logic [SEL_W-1:0] REG_DI = 3'd7;

  // Frame slots: last slot index, and the saved SP slot that a full pop skips
  localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd7;
  localparam logic [SLOT_W-1:0] SLOT_SP   = 3'd4;

  // Register held in each slot of a full frame, lowest address first
  function automatic logic [SEL_W-1:0] slot_reg(input logic [SLOT_W-1:0] slot);
    logic [SEL_W-1:0] r;
    unique case (slot)
      3'd0:    r = REG_AX;
      3'd1:    r = REG_BX;
      3'd2:    r = REG_DX;
      3'd3:    r = REG_CX;
      3'd4:    r = REG_SP;
      3'd5:    r = REG_BP;
      3'd6:    r = REG_SI;
      default: r = REG_DI;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/zosf_alu.sv @@
// Shared 64-bit add/subtract unit with carry out for pointer math and bound checks.
`timescale 1ns / 1ps
`default_nettype none
module zosf_alu (
  input  wire logic                     sub,
  input  wire logic [zosf_pkg::XLEN-1:0] a,
  input  wire logic [zosf_pkg::XLEN-1:0] b,
  output logic      [zosf_pkg::XLEN-1:0] sum,
  output logic                          cout
);
  import zosf_pkg::*;

  logic [XLEN-1:0] b_eff;

  // a + b, or a - b as a + ~b + 1; on subtract cout high means a >= b
  assign b_eff = sub ? ~b : b;
  assign {cout, sum} = {1'b0, a} + {1'b0, b_eff} + (XLEN+1)'(sub);

endmodule
`default_nettype wire

@@ rtl/zosf_word_index.sv @@
// Maps a byte address (as its word number) to a stack word index, modulo the depth.
`timescale 1ns / 1ps
`default_nettype none
module zosf_word_index #(
  parameter int unsigned DEPTH = zosf_pkg::STACK_WORDS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [zosf_pkg::XLEN-4:0] value,
  output logic      [AW-1:0]             idx,
  output logic                           done
);
  import zosf_pkg::*;

  localparam bit IsPow2 = ((DEPTH & (DEPTH - 1)) == 0);

  // Residue of each power of two modulo the depth, one AW-bit entry per bit position
  function automatic logic [XLEN*AW-1:0] residue_table();
    logic [XLEN*AW-1:0] tab;
    logic [AW:0]        r;
    tab = '0;
    r   = (AW+1)'(1);
    for (int i = 0; i < XLEN - 3; i++) begin
      tab[i*AW +: AW] = r[AW-1:0];
      r = {r[AW-1:0], 1'b0};
      if (r >= (AW+1)'(DEPTH)) begin
        r = r - (AW+1)'(DEPTH);
      end
    end
    return tab;
  endfunction

  generate
    if (IsPow2) begin : g_mask
      // Power-of-two depth: the index is the low word bits
      logic [AW-1:0] idx_r;
      logic          done_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          idx_r <= value[AW-1:0];
        end
      end

      assign idx  = idx_r;
      assign done = done_r;
    end else begin : g_residue
      // Other depths: add up the residues of the set bits, eight bits a cycle,
      // then fold the sum below DEPTH by compare and subtract, two steps a cycle
      localparam int unsigned Chunk    = 8;
      localparam int unsigned ValW     = XLEN;
      localparam int unsigned PadW     = ValW - (XLEN - 3);
      localparam int unsigned SumW     = AW + 6;
      localparam logic [2:0]  AccLast  = 3'd7;
      localparam logic [2:0]  FoldLast = 3'd2;
      localparam logic [XLEN*AW-1:0] ResTab = residue_table();

      logic [ValW-1:0] val_r;
      logic [SumW-1:0] acc_r;
      logic [2:0]      cnt_r;
      logic            busy_r;
      logic            fold_r;
      logic            done_r;

      logic [SumW-1:0] term [Chunk];
      logic [SumW-1:0] pair [Chunk/2];
      logic [SumW-1:0] quad [Chunk/4];
      logic [SumW-1:0] acc_sum;
      logic [SumW-1:0] dsh_a, dsh_b, fold_a, fold_b;

      // Residue sum of the low eight value bits, as an adder tree
      always_comb begin
        for (int j = 0; j < Chunk; j++) begin
          term[j] = val_r[j] ? SumW'(ResTab[(int'(cnt_r) * Chunk + j) * AW +: AW]) : '0;
        end
        for (int j = 0; j < Chunk / 2; j++) begin
          pair[j] = term[2*j] + term[2*j+1];
        end
        quad[0] = pair[0] + pair[1];
        quad[1] = pair[2] + pair[3];
        acc_sum = acc_r + (quad[0] + quad[1]);
      end

      // Two fold steps: subtract DEPTH shifted by 5,4 then 3,2 then 1,0
      always_comb begin
        dsh_a  = SumW'(DEPTH) << (3'd5 - {cnt_r[1:0], 1'b0});
        dsh_b  = SumW'(DEPTH) << (3'd4 - {cnt_r[1:0], 1'b0});
        fold_a = (acc_r >= dsh_a) ? acc_r - dsh_a : acc_r;
        fold_b = (fold_a >= dsh_b) ? fold_a - dsh_b : fold_a;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          fold_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= busy_r && fold_r && (cnt_r == FoldLast);
          if (start) begin
            busy_r <= 1'b1;
            fold_r <= 1'b0;
            cnt_r  <= '0;
          end else if (busy_r) begin
            if (!fold_r) begin
              if (cnt_r == AccLast) begin
                fold_r <= 1'b1;
                cnt_r  <= '0;
              end else begin
                cnt_r <= cnt_r + 3'd1;
              end
            end else if (cnt_r == FoldLast) begin
              busy_r <= 1'b0;
            end else begin
              cnt_r <= cnt_r + 3'd1;
            end
          end
        end
        if (start) begin
          val_r <= {{PadW{1'b0}}, value};
          acc_r <= '0;
        end else if (busy_r) begin
          if (!fold_r) begin
            val_r <= val_r >> Chunk;
            acc_r <= acc_sum;
          end else begin
            acc_r <= fold_b;
          end
        end
      end

      assign idx  = acc_r[AW-1:0];
      assign done = done_r;
    end
  endgenerate

endmodule
`default_nettype wire

@@ rtl/zosf_stack_ram.sv @@
// Single-port stack word memory with registered read and a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module zosf_stack_ram #(
  parameter int unsigned DEPTH = zosf_pkg::STACK_WORDS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [zosf_pkg::XLEN-1:0] wdata,
  output logic      [zosf_pkg::XLEN-1:0] rdata,
  output logic                           busy
);
  import zosf_pkg::*;

  logic [XLEN-1:0] mem [DEPTH];
  logic [XLEN-1:0] rdata_r;
  logic [AW-1:0]   clr_r;
  logic            busy_r;

  // Clear sweep after reset, word by word from the first index to the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + AW'(1);
      if (clr_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Storage: clear has priority over user writes
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= '0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule
`default_nettype wire

@@ rtl/zero_operand_stack_flag_unit.sv @@
// Top level of the zero-operand stack and flag unit: sequencer, register file and ports.
`timescale 1ns / 1ps
`default_nettype none
// Executes one zero-operand instruction per input transfer and returns one result
// transfer for it. The block takes one instruction at a time; in_tready is low while
// it works. Register, carry and flag moves (NOP, STC, CLC, CMC, LAF, SAF, LAIP, SAIP,
// register write) go from the execute state straight to the result. Stack instructions
// update SP and check the bound on one shared 64-bit adder, then find the word index,
// then make one stack memory access per cycle on a single port; a failed bound check
// goes straight to the result. With a STACK_WORDS that is not a power of two the word
// index is found by a residue sum and fold instead of the low bits. After reset the
// stack memory is cleared, one word a cycle, and no instruction is taken until the clear
// is done; configuration writes are taken at any time the block is idle.
module zero_operand_stack_flag_unit #(
  parameter int unsigned STACK_WORDS = zosf_pkg::STACK_WORDS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [2:0] reg_select, [66:3] write_value, rest zero
  input  wire logic [zosf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [3:0] opcode
  input  wire logic [zosf_pkg::OPCODE_W-1:0]    in_tuser,
  // Result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [0] stop_request, [64:1] fault_address, [128:65] ip_now,
  // [192:129] flags_now, [256:193] reg_readback, rest zero
  output logic      [zosf_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] status
  output logic                                  out_tuser,
  // Configuration port
  input  wire logic                             cfg_wr_en,
  input  wire logic [zosf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [zosf_pkg::XLEN-1:0]        cfg_wdata
);
  import zosf_pkg::*;

  localparam int unsigned AW = $clog2(STACK_WORDS);
  localparam int unsigned OutPadW = OUT_TDATA_W - (1 + 4 * XLEN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_INDEX,
    S_MEM,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [OPCODE_W-1:0] op_r;
  logic [SEL_W-1:0]  sel_r;
  logic [XLEN-1:0]   wval_r;
  logic [XLEN-1:0]   bottom_r;
  logic [XLEN-1:0]   top_r;
  logic [XLEN-1:0]   regs_r [NUM_REGS];
  logic [XLEN-1:0]   flags_r;
  logic [XLEN-1:0]   ip_r;
  logic [XLEN-1:0]   old_sp_r;
  logic [XLEN-1:0]   base_r;
  logic [AW-1:0]     base_idx_r;
  logic [SLOT_W-1:0] k_r;
  logic              err_r;
  logic              rd_pend_r;
  logic [SLOT_W-1:0] rd_k_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic              out_user_r;

  // Instruction class decode
  logic is_push, is_pop, is_frame, is_stack;
  assign is_push  = (op_r == OP_PUSHF) || (op_r == OP_PUSHA);
  assign is_pop   = (op_r == OP_RET) || (op_r == OP_POPF) || (op_r == OP_POPA);
  assign is_frame = (op_r == OP_PUSHA) || (op_r == OP_POPA);
  assign is_stack = is_push || is_pop;

  logic [XLEN-1:0] sp_cur;
  logic [XLEN-1:0] sp_step;
  logic [XLEN-1:0] carry_mask;
  assign sp_cur     = regs_r[REG_SP];
  assign sp_step    = is_frame ? FRAME_STEP : WORD_STEP;
  assign carry_mask = XLEN'(1) << CARRY_BIT;

  // Shared adder operand select
  logic            alu_sub;
  logic [XLEN-1:0] alu_a, alu_b, alu_sum;
  logic            alu_cout;

  always_comb begin
    alu_sub = 1'b0;
    alu_a   = sp_cur;
    alu_b   = sp_step;
    unique case (state_r)
      S_EXEC: begin
        alu_sub = !is_push;
      end
      S_CHECK: begin
        alu_sub = 1'b1;
        alu_a   = is_push ? top_r : sp_cur;
        alu_b   = is_push ? sp_cur : bottom_r;
      end
      S_MEM: begin
        alu_a = base_r;
        alu_b = {{(XLEN-SLOT_W-3){1'b0}}, k_r, 3'b000};
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  zosf_alu u_alu (
    .sub  (alu_sub),
    .a    (alu_a),
    .b    (alu_b),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  // Frame base: old SP for pushes, new SP for pops
  logic [XLEN-1:0] base_sel;
  logic            idx_start;
  logic [AW-1:0]   idx_res;
  logic            idx_done;
  assign base_sel  = is_push ? old_sp_r : sp_cur;
  assign idx_start = (state_r == S_CHECK) && alu_cout;

  zosf_word_index #(
    .DEPTH (STACK_WORDS),
    .AW    (AW)
  ) u_word_index (
    .clk   (clk),
    .rst_n (rst_n),
    .start (idx_start),
    .value (base_sel[XLEN-1:3]),
    .idx   (idx_res),
    .done  (idx_done)
  );

  // Word index of the current slot; an address that wrapped past 2^64 is a low word
  logic [AW:0]   idx_sum, idx_wrap;
  logic [AW-1:0] mem_idx;
  always_comb begin
    idx_sum  = {1'b0, base_idx_r} + (AW+1)'(k_r);
    idx_wrap = (idx_sum >= (AW+1)'(STACK_WORDS)) ? idx_sum - (AW+1)'(STACK_WORDS) : idx_sum;
    mem_idx  = alu_cout ? AW'(alu_sum[5:3]) : idx_wrap[AW-1:0];
  end

  // Register file read port
  logic [SEL_W-1:0] rf_raddr;
  logic [XLEN-1:0]  rf_rdata;
  assign rf_raddr = (state_r == S_MEM) ? slot_reg(k_r) : sel_r;
  assign rf_rdata = regs_r[rf_raddr];

  // Stack memory
  logic            ram_we;
  logic [XLEN-1:0] ram_wdata, ram_rdata;
  logic            ram_busy;
  assign ram_we    = (state_r == S_MEM) && is_push;
  assign ram_wdata = (op_r == OP_PUSHF) ? flags_r : rf_rdata;

  zosf_stack_ram #(
    .DEPTH (STACK_WORDS),
    .AW    (AW)
  ) u_stack_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .addr  (mem_idx),
    .wdata (ram_wdata),
    .rdata (ram_rdata),
    .busy  (ram_busy)
  );

  // Register file write port
  logic             rf_we;
  logic [SEL_W-1:0] rf_widx;
  logic [XLEN-1:0]  rf_wdata;
  always_comb begin
    rf_we    = 1'b0;
    rf_widx  = sel_r;
    rf_wdata = wval_r;
    if (state_r == S_EXEC) begin
      if (is_stack) begin
        rf_we    = 1'b1;
        rf_widx  = REG_SP;
        rf_wdata = alu_sum;
      end else if (op_r == OP_LAF) begin
        rf_we    = 1'b1;
        rf_widx  = REG_AX;
        rf_wdata = flags_r;
      end else if (op_r == OP_LAIP) begin
        rf_we    = 1'b1;
        rf_widx  = REG_AX;
        rf_wdata = ip_r;
      end else if (op_r == OP_WREG) begin
        rf_we = 1'b1;
      end
    end else if (rd_pend_r && (op_r == OP_POPA) && (rd_k_r != SLOT_SP)) begin
      rf_we    = 1'b1;
      rf_widx  = slot_reg(rd_k_r);
      rf_wdata = ram_rdata;
    end
  end

  logic in_xfer;
  logic slot_last;
  logic out_load;
  assign in_tready = (state_r == S_IDLE) && !ram_busy;
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_last = is_frame ? (k_r == SLOT_LAST) : 1'b1;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Sequencer, architectural state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bottom_r    <= STACK_BOTTOM_RST;
      top_r       <= STACK_TOP_RST;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
      flags_r     <= '0;
      ip_r        <= '0;
      err_r       <= 1'b0;
      rd_pend_r   <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_STACK_BOTTOM: bottom_r <= cfg_wdata;
          default:          top_r    <= cfg_wdata;
        endcase
      end

      if (rf_we) begin
        regs_r[rf_widx] <= rf_wdata;
      end

      // Landing of a stack read issued last cycle
      if (rd_pend_r) begin
        if (op_r == OP_RET) begin
          ip_r <= ram_rdata;
        end else if (op_r == OP_POPF) begin
          flags_r <= ram_rdata;
        end
      end
      rd_pend_r <= (state_r == S_MEM) && !is_push;

      // Result valid: set on a new result, cleared when the waiting one is taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r    <= in_tuser;
            sel_r   <= in_tdata[SEL_W-1:0];
            wval_r  <= in_tdata[SEL_W +: XLEN];
            err_r   <= 1'b0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          old_sp_r <= sp_cur;
          if (op_r == OP_STC) begin
            flags_r <= flags_r | carry_mask;
          end else if (op_r == OP_CLC) begin
            flags_r <= flags_r & ~carry_mask;
          end else if (op_r == OP_CMC) begin
            flags_r <= flags_r ^ carry_mask;
          end else if (op_r == OP_SAF) begin
            flags_r <= regs_r[REG_AX];
          end else if (op_r == OP_SAIP) begin
            ip_r <= regs_r[REG_AX];
          end
          state_r <= is_stack ? S_CHECK : S_OUT;
        end
        S_CHECK: begin
          if (alu_cout) begin
            base_r  <= base_sel;
            state_r <= S_INDEX;
          end else begin
            err_r   <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_INDEX: begin
          if (idx_done) begin
            base_idx_r <= idx_res;
            k_r        <= '0;
            state_r    <= S_MEM;
          end
        end
        S_MEM: begin
          rd_k_r <= k_r;
          if (slot_last) begin
            state_r <= is_push ? S_OUT : S_DRAIN;
          end else begin
            k_r <= k_r + SLOT_W'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_user_r  <= err_r;
            out_data_r  <= {{OutPadW{1'b0}}, rf_rdata, flags_r, ip_r,
                            (err_r ? sp_cur : {XLEN{1'b0}}), err_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench of the zero-operand stack and flag unit.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import zosf_pkg::*;

  localparam int unsigned STK_WORDS = STACK_WORDS_DEF;
  localparam logic [XLEN-1:0] ALL_ONES = {XLEN{1'b1}};

  // Register order of a full frame, lowest address first
  localparam logic [SEL_W-1:0] FRAME_ORDER [NUM_REGS] =
    '{REG_AX, REG_BX, REG_DX, REG_CX, REG_SP, REG_BP, REG_SI, REG_DI};

  typedef struct packed {
    logic            status;
    logic            stop;
    logic [XLEN-1:0] fault;
    logic [XLEN-1:0] ip;
    logic [XLEN-1:0] flags;
    logic [XLEN-1:0] readback;
  } step_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OPCODE_W-1:0]    in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [XLEN-1:0]        cfg_wdata;

  // Predicted machine state and bounds
  logic [XLEN-1:0] mdl_regs [NUM_REGS];
  logic [XLEN-1:0] mdl_flags;
  logic [XLEN-1:0] mdl_ip;
  logic [XLEN-1:0] mdl_stack [STK_WORDS];
  logic [XLEN-1:0] bound_lo;
  logic [XLEN-1:0] bound_hi;

  step_result_t pending_results [$];
  int unsigned  mismatches = 0;
  int unsigned  checked    = 0;
  int unsigned  instr_cnt  = 0;
  int unsigned  stack_errs = 0;
  int unsigned  settings   = 1;
  bit           quiet      = 1'b0;

  zero_operand_stack_flag_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(0, 99) >= 7);
  end

  // Stack word selected by a byte address
  function automatic int unsigned word_idx(input logic [XLEN-1:0] addr);
    return int'((addr >> 3) % STK_WORDS);
  endfunction

  // Execute one instruction on the predicted state
  function automatic step_result_t exec_instr(input logic [OPCODE_W-1:0] op,
                                              input logic [SEL_W-1:0] sel,
                                              input logic [XLEN-1:0] val);
    step_result_t r;
    logic bad;
    logic [XLEN-1:0] sp;
    int k;
    bad = 1'b0;
    case (op)
      OP_RET, OP_POPF: begin
        sp = mdl_regs[REG_SP] - WORD_STEP;
        mdl_regs[REG_SP] = sp;
        if (bound_lo <= sp) begin
          if (op == OP_RET) mdl_ip = mdl_stack[word_idx(sp)];
          else mdl_flags = mdl_stack[word_idx(sp)];
        end else begin
          bad = 1'b1;
        end
      end
      OP_STC: mdl_flags[CARRY_BIT] = 1'b1;
      OP_CLC: mdl_flags[CARRY_BIT] = 1'b0;
      OP_CMC: mdl_flags[CARRY_BIT] = ~mdl_flags[CARRY_BIT];
      OP_PUSHF: begin
        sp = mdl_regs[REG_SP] + WORD_STEP;
        mdl_regs[REG_SP] = sp;
        if (bound_hi >= sp) mdl_stack[word_idx(sp - WORD_STEP)] = mdl_flags;
        else bad = 1'b1;
      end
      OP_PUSHA: begin
        sp = mdl_regs[REG_SP] + FRAME_STEP;
        mdl_regs[REG_SP] = sp;
        // saved SP slot holds the moved pointer
        if (bound_hi >= sp) begin
          for (k = 0; k < NUM_REGS; k++)
            mdl_stack[word_idx(sp - FRAME_STEP + 8 * k)] = mdl_regs[FRAME_ORDER[k]];
        end else begin
          bad = 1'b1;
        end
      end
      OP_POPA: begin
        sp = mdl_regs[REG_SP] - FRAME_STEP;
        mdl_regs[REG_SP] = sp;
        // saved SP slot is skipped, SP stays at the frame base
        if (bound_lo <= sp) begin
          for (k = 0; k < NUM_REGS; k++)
            if (FRAME_ORDER[k] != REG_SP)
              mdl_regs[FRAME_ORDER[k]] = mdl_stack[word_idx(sp + 8 * k)];
        end else begin
          bad = 1'b1;
        end
      end
      OP_LAF:  mdl_regs[REG_AX] = mdl_flags;
      OP_SAF:  mdl_flags = mdl_regs[REG_AX];
      OP_LAIP: mdl_regs[REG_AX] = mdl_ip;
      OP_SAIP: mdl_ip = mdl_regs[REG_AX];
      OP_WREG: mdl_regs[sel] = val;
      default: ;
    endcase
    r.status   = bad;
    r.stop     = bad;
    r.fault    = bad ? mdl_regs[REG_SP] : '0;
    r.ip       = mdl_ip;
    r.flags    = mdl_flags;
    r.readback = mdl_regs[sel];
    return r;
  endfunction

  // Send one instruction; valid stays high after the transfer
  task automatic send_instr(input logic [OPCODE_W-1:0] op, input logic [SEL_W-1:0] sel,
                            input logic [XLEN-1:0] val);
    step_result_t r;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 7) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - XLEN - SEL_W){1'b0}}, val, sel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = exec_instr(op, sel, val);
    if (r.status) stack_errs++;
    instr_cnt++;
    pending_results.push_back(r);
  endtask

  // Stop sending and let every expected result arrive
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Write both stack bounds while the block is idle
  task automatic set_bounds(input logic [XLEN-1:0] lo, input logic [XLEN-1:0] hi);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_STACK_BOTTOM;
    cfg_wdata <= lo;
    @(posedge clk);
    bound_lo = lo;
    cfg_index <= CFG_STACK_TOP;
    cfg_wdata <= hi;
    @(posedge clk);
    bound_hi = hi;
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  // Result checker
  always @(posedge clk) begin
    step_result_t act;
    step_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      act.status   = out_tuser;
      act.stop     = out_tdata[0];
      act.fault    = out_tdata[64:1];
      act.ip       = out_tdata[128:65];
      act.flags    = out_tdata[192:129];
      act.readback = out_tdata[256:193];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: result transfer with nothing expected at %0t", $realtime);
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        if (act !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: mismatch on result %0d at %0t", checked, $realtime);
            $display("  exp st=%0b stop=%0b fault=%h ip=%h flags=%h rb=%h", exp_r.status,
                     exp_r.stop, exp_r.fault, exp_r.ip, exp_r.flags, exp_r.readback);
            $display("  act st=%0b stop=%0b fault=%h ip=%h flags=%h rb=%h", act.status,
                     act.stop, act.fault, act.ip, act.flags, act.readback);
          end
        end
      end
    end
  end

  // Register readback straight after reset
  task automatic test_reset_readback();
    send_instr(OP_NOP, REG_AX, '0);
    send_instr(OP_NOP, REG_DI, ALL_ONES);
  endtask

  // Carry set, clear and complement
  task automatic test_carry_ops();
    send_instr(OP_STC, REG_BX, '0);
    send_instr(OP_CMC, REG_CX, '0);
    send_instr(OP_CLC, REG_DX, '0);
    send_instr(OP_CMC, REG_SP, '0);
  endtask

  // Moves between AX, the flag word and the instruction pointer
  task automatic test_flag_ip_moves();
    send_instr(OP_WREG, REG_AX, ALL_ONES);
    send_instr(OP_SAF, REG_AX, '0);
    send_instr(OP_CLC, REG_AX, '0);
    send_instr(OP_LAF, REG_AX, '0);
    send_instr(OP_SAIP, REG_BP, '0);
    send_instr(OP_LAIP, REG_AX, '0);
  endtask

  // Pushes and pops in bounds, the last pop wrapping below zero
  task automatic test_push_pop();
    send_instr(OP_PUSHF, REG_SP, '0);
    send_instr(OP_PUSHA, REG_SP, '0);
    send_instr(OP_POPA, REG_SI, '0);
    send_instr(OP_POPF, REG_AX, '0);
    send_instr(OP_RET, REG_SP, '0);
  endtask

  // Underflow, overflow and a push that lands exactly on the top bound
  task automatic test_bound_errors();
    set_bounds(64'd16, 64'd64);
    send_instr(OP_WREG, REG_SP, 64'd16);
    send_instr(OP_POPF, REG_SP, '0);
    send_instr(OP_PUSHA, REG_SP, '0);
    send_instr(OP_WREG, REG_SP, 64'd56);
    send_instr(OP_PUSHF, REG_SP, '0);
    send_instr(OP_POPA, REG_SP, '0);
  endtask

  // Opcodes without a function
  task automatic test_unused_ops();
    send_instr(4'd14, REG_CX, '0);
    send_instr(4'd15, REG_DI, '0);
  endtask

  // Random instruction mix around the given bounds
  task automatic test_random_phase(input logic [XLEN-1:0] lo, input logic [XLEN-1:0] hi,
                                   input int unsigned n, input bit no_idle);
    int unsigned pick;
    logic [OPCODE_W-1:0] op;
    logic [SEL_W-1:0] sel;
    logic [XLEN-1:0] val;
    int offs;
    set_bounds(lo, hi);
    quiet = no_idle;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      sel  = SEL_W'($urandom_range(0, NUM_REGS - 1));
      val  = {$urandom, $urandom};
      if      (pick < 15) op = OP_PUSHA;
      else if (pick < 30) op = OP_POPA;
      else if (pick < 40) op = OP_PUSHF;
      else if (pick < 50) op = OP_POPF;
      else if (pick < 56) op = OP_RET;
      else if (pick < 62) op = OPCODE_W'($urandom_range(OP_STC, OP_CMC));
      else if (pick < 70) op = OPCODE_W'($urandom_range(OP_LAF, OP_SAIP));
      else if (pick < 74) op = OPCODE_W'($urandom_range(0, 2) == 0 ? OP_NOP
                                                                    : $urandom_range(14, 15));
      else if (pick < 90) op = OP_WREG;
      else begin
        // place SP just around one of the bounds
        op   = OP_WREG;
        sel  = REG_SP;
        offs = int'($urandom_range(0, 160)) - 80;
        val  = ($urandom_range(0, 1) ? bound_lo : bound_hi) + XLEN'(signed'(offs));
      end
      send_instr(op, sel, val);
      if ($urandom_range(0, 99) == 0) wait_idle();
    end
    quiet = 1'b0;
  endtask

  // Test sequence
  initial begin
    logic [XLEN-1:0] base;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_NOP;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_STACK_BOTTOM;
    cfg_wdata <= '0;
    for (int i = 0; i < NUM_REGS; i++) mdl_regs[i] = '0;
    for (int i = 0; i < STK_WORDS; i++) mdl_stack[i] = '0;
    mdl_flags = '0;
    mdl_ip    = '0;
    bound_lo  = STACK_BOTTOM_RST;
    bound_hi  = STACK_TOP_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_readback();
    test_carry_ops();
    test_flag_ip_moves();
    test_push_pop();
    test_bound_errors();
    test_unused_ops();

    test_random_phase(STACK_BOTTOM_RST, STACK_TOP_RST, 250, 1'b0);
    test_random_phase('0, ALL_ONES, 200, 1'b0);
    test_random_phase(ALL_ONES, '0, 100, 1'b0);
    test_random_phase(64'd256, 64'd1024, 250, 1'b1);
    base = XLEN'($urandom_range(0, 255)) << 3;
    test_random_phase(base, base + XLEN'($urandom_range(64, 1500)), 250, 1'b0);

    wait_idle();
    $display("tb: %0d instructions over %0d bound settings, %0d of them stack bound errors",
             instr_cnt, settings, stack_errs);
    $display("tb: %0d results checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
